### rtl/fbab_pkg.sv
package fbab_pkg;

    localparam int FRAME_WORDS = 16384;
    localparam int PIXEL_BITS  = 32;
    localparam int ADDR_W      = $clog2(FRAME_WORDS);
    localparam int REG_W       = 13;
    localparam int COORD_W     = 12;
    localparam int FULL_W      = 2 * REG_W + 1;
    localparam int CH_W        = 8;
    localparam int COLOR_CHANS = 3;
    localparam int ALPHA_LSB   = 24;
    localparam int CFG_IDX_W   = 2;

    localparam logic [REG_W-1:0]     REG_RESET  = REG_W'(128);
    localparam logic [CH_W-1:0]      CHAN_MAX   = 8'hFF;
    localparam logic [FULL_W-1:0]    FULL_LIMIT = FULL_W'(FRAME_WORDS);
    localparam logic [ADDR_W-1:0]    CLEAR_LAST = ADDR_W'(FRAME_WORDS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH     = 2'd2;

    localparam logic ACT_BLEND = 1'b0;
    localparam logic ACT_FILL  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_READ,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef logic [PIXEL_BITS-1:0] t_pixel;

endpackage

### rtl/fbab_blend.sv
module fbab_blend (
    input  logic               i_clk,
    input  fbab_pkg::t_pixel   i_dst,
    input  fbab_pkg::t_pixel   i_src,
    output fbab_pkg::t_pixel   o_word
);

    localparam int CW = fbab_pkg::CH_W;
    localparam int NC = fbab_pkg::COLOR_CHANS;
    localparam int AL = fbab_pkg::ALPHA_LSB;

    logic [CW-1:0] src_a;
    logic [CW-1:0] dst_a;
    logic [NC-1:0][2*CW-1:0] sp_prod;
    logic [NC-1:0][2*CW-1:0] dp_prod;
    logic [2*CW-1:0] ap_prod;

    logic [NC-1:0][2*CW-1:0] r1_sp;
    logic [NC-1:0][2*CW-1:0] r1_dp;
    logic [2*CW-1:0] r1_ap;
    logic [CW-1:0] r1_da;
    logic [CW-1:0] r1_na;

    logic [NC-1:0][31:0] sq_prod;
    logic [NC-1:0][3*CW-1:0] dn_prod;
    logic [31:0] aq_prod;

    logic [NC-1:0][CW-1:0] r2_sq;
    logic [NC-1:0][3*CW-1:0] r2_dn;
    logic [CW-1:0] r2_aq;
    logic [CW-1:0] r2_da;

    logic [NC-1:0][47:0] dq_prod;
    logic [CW:0] oa_sum;

    logic [NC-1:0][CW-1:0] r3_sq;
    logic [NC-1:0][CW-1:0] r3_dq;
    logic [CW-1:0] r3_oa;

    logic [NC-1:0][CW:0] ch_sum;

    assign src_a = i_src[AL +: CW];
    assign dst_a = i_dst[AL +: CW];

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            sp_prod[c] = (2*CW)'(i_src[CW*c +: CW]) * (2*CW)'(src_a);
            dp_prod[c] = (2*CW)'(i_dst[CW*c +: CW]) * (2*CW)'(dst_a);
        end
        ap_prod = (2*CW)'(fbab_pkg::CHAN_MAX - dst_a) * (2*CW)'(src_a);
    end

    always_ff @(posedge i_clk) begin
        r1_sp <= sp_prod;
        r1_dp <= dp_prod;
        r1_ap <= ap_prod;
        r1_da <= dst_a;
        r1_na <= fbab_pkg::CHAN_MAX - src_a;
    end

    // Division by 255 of a 16-bit value is a multiply by 0x8081 and a shift by 23.
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            sq_prod[c] = 32'(r1_sp[c]) * 32'h0000_8081;
            dn_prod[c] = (3*CW)'(r1_dp[c]) * (3*CW)'(r1_na);
        end
        aq_prod = 32'(r1_ap) * 32'h0000_8081;
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NC; c++) begin
            r2_sq[c] <= sq_prod[c][30:23];
            r2_dn[c] <= dn_prod[c];
        end
        r2_aq <= aq_prod[30:23];
        r2_da <= r1_da;
    end

    // Division by 65025 of a value up to 255 cubed is a multiply by 0x1020305
    // and a shift by 40.
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            dq_prod[c] = 48'(r2_dn[c]) * 48'h0000_0102_0305;
        end
        oa_sum = (CW+1)'(r2_da) + (CW+1)'(r2_aq);
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NC; c++) begin
            r3_sq[c] <= r2_sq[c];
            r3_dq[c] <= dq_prod[c][47:40];
        end
        r3_oa <= oa_sum[CW-1:0];
    end

    always_comb begin
        o_word = '0;
        for (int c = 0; c < NC; c++) begin
            ch_sum[c] = (CW+1)'(r3_sq[c]) + (CW+1)'(r3_dq[c]);
            o_word[CW*c +: CW] = ch_sum[c][CW-1:0];
        end
        o_word[AL +: CW] = r3_oa;
    end

endmodule

### rtl/framebuffer_alpha_blender.sv
// Single blend: the beat passes ADDR, READ, MUL1, MUL2, MUL3, WRITE and DONE; a dropped
// address goes from READ to DONE. Fill: each pixel passes ADDR and READ, then MUL1 to WRITE
// when inside memory; DONE follows the last pixel. One item is worked at a time, so no
// new beat is taken until the last is done; a finished result waits in the output register.
// Reset is synchronous and active low; afterwards a clearing pass writes zero
// to all 16384 words, one per cycle, and no input beat is taken until it ends.
module framebuffer_alpha_blender (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_action,
    input  logic [fbab_pkg::COORD_W-1:0]         i_x,
    input  logic [fbab_pkg::COORD_W-1:0]         i_y,
    input  logic [fbab_pkg::PIXEL_BITS-1:0]      i_color,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [fbab_pkg::PIXEL_BITS-1:0]      o_pixel_value,
    output logic                                 o_status,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fbab_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fbab_pkg::REG_W-1:0]           i_cfg_data
);

    localparam int AW = fbab_pkg::ADDR_W;
    localparam int RW = fbab_pkg::REG_W;
    localparam int FW = fbab_pkg::FULL_W;

    fbab_pkg::t_pixel mem [fbab_pkg::FRAME_WORDS];

    fbab_pkg::t_state r_state, n_state;
    logic [RW-1:0] r_width, r_height, r_pitch;
    logic [RW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          r_fill, n_fill;
    logic          r_drop, n_drop;
    fbab_pkg::t_pixel r_color, n_color;
    fbab_pkg::t_pixel r_result, n_result;
    logic [FW-1:0] r_full, n_full;
    logic [AW-1:0] r_clr, n_clr;
    logic          r_out_valid, n_out_valid;
    fbab_pkg::t_pixel r_pixel_value, n_pixel_value;
    logic          r_status, n_status;
    fbab_pkg::t_pixel r_rdata;

    fbab_pkg::t_pixel blend_word;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    fbab_pkg::t_pixel mem_wdata;
    logic          out_free;
    logic          last_row, last_col;
    logic          in_accept;

    fbab_blend u_blend (
        .i_clk (i_clk),
        .i_dst (r_rdata),
        .i_src (r_color),
        .o_word(blend_word)
    );

    assign o_in_ready    = (r_state == fbab_pkg::ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_pixel_value = r_pixel_value;
    assign o_status      = r_status;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign last_row  = (r_row + RW'(1)) == r_height;
    assign last_col  = (r_col + RW'(1)) == r_width;

    assign mem_we    = (r_state == fbab_pkg::ST_CLEAR) || (r_state == fbab_pkg::ST_WRITE);
    assign mem_waddr = (r_state == fbab_pkg::ST_CLEAR) ? r_clr : r_full[AW-1:0];
    assign mem_wdata = (r_state == fbab_pkg::ST_CLEAR) ? '0 : blend_word;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[r_full[AW-1:0]];
    end

    always_comb begin
        n_state       = r_state;
        n_col         = r_col;
        n_row         = r_row;
        n_fill        = r_fill;
        n_drop        = r_drop;
        n_color       = r_color;
        n_result      = r_result;
        n_full        = r_full;
        n_clr         = r_clr;
        n_out_valid   = r_out_valid;
        n_pixel_value = r_pixel_value;
        n_status      = r_status;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            fbab_pkg::ST_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == fbab_pkg::CLEAR_LAST) begin
                    n_state = fbab_pkg::ST_IDLE;
                end
            end
            fbab_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_fill   = (i_action == fbab_pkg::ACT_FILL);
                    n_color  = i_color;
                    n_drop   = 1'b0;
                    n_result = '0;
                    if (i_action == fbab_pkg::ACT_FILL) begin
                        n_col = '0;
                        n_row = '0;
                        if (r_width == '0 || r_height == '0) begin
                            n_state = fbab_pkg::ST_DONE;
                        end else begin
                            n_state = fbab_pkg::ST_ADDR;
                        end
                    end else begin
                        n_col   = RW'(i_x);
                        n_row   = RW'(i_y);
                        n_state = fbab_pkg::ST_ADDR;
                    end
                end
            end
            fbab_pkg::ST_ADDR: begin
                n_full  = FW'(r_row) * FW'(r_pitch) + FW'(r_col);
                n_state = fbab_pkg::ST_READ;
            end
            fbab_pkg::ST_READ: begin
                if (r_full >= fbab_pkg::FULL_LIMIT) begin
                    n_drop = 1'b1;
                    if (!r_fill || (last_row && last_col)) begin
                        n_state = fbab_pkg::ST_DONE;
                    end else begin
                        n_state = fbab_pkg::ST_ADDR;
                    end
                    if (r_fill && last_row) begin
                        n_row = '0;
                        n_col = last_col ? '0 : r_col + RW'(1);
                    end else if (r_fill) begin
                        n_row = r_row + RW'(1);
                    end
                end else begin
                    n_state = fbab_pkg::ST_MUL1;
                end
            end
            fbab_pkg::ST_MUL1: n_state = fbab_pkg::ST_MUL2;
            fbab_pkg::ST_MUL2: n_state = fbab_pkg::ST_MUL3;
            fbab_pkg::ST_MUL3: n_state = fbab_pkg::ST_WRITE;
            fbab_pkg::ST_WRITE: begin
                if (!r_fill) begin
                    n_result = blend_word;
                end
                if (!r_fill || (last_row && last_col)) begin
                    n_state = fbab_pkg::ST_DONE;
                end else begin
                    n_state = fbab_pkg::ST_ADDR;
                end
                if (r_fill && last_row) begin
                    n_row = '0;
                    n_col = last_col ? '0 : r_col + RW'(1);
                end else if (r_fill) begin
                    n_row = r_row + RW'(1);
                end
            end
            fbab_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_pixel_value = r_result;
                    n_status      = r_drop;
                    n_col         = '0;
                    n_row         = '0;
                    n_state       = fbab_pkg::ST_IDLE;
                end
            end
            default: n_state = fbab_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fbab_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_fill      <= 1'b0;
            r_drop      <= 1'b0;
            r_full      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_col       <= n_col;
            r_row       <= n_row;
            r_fill      <= n_fill;
            r_drop      <= n_drop;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_color       <= n_color;
        r_result      <= n_result;
        r_pixel_value <= n_pixel_value;
        r_status      <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= fbab_pkg::REG_RESET;
            r_height <= fbab_pkg::REG_RESET;
            r_pitch  <= fbab_pkg::REG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == fbab_pkg::CFG_SCREEN_WIDTH) begin
                r_width <= i_cfg_data;
            end
            if (i_cfg_index == fbab_pkg::CFG_SCREEN_HEIGHT) begin
                r_height <= i_cfg_data;
            end
            if (i_cfg_index == fbab_pkg::CFG_ROW_PITCH) begin
                r_pitch <= i_cfg_data;
            end
        end
    end

endmodule
